// ===== sv/i2a_pkg.sv =====
package i2a_pkg;

  localparam int VALUE_WIDTH         = 32;
  localparam int CHAR_WIDTH          = 7;
  localparam int WORD_WIDTH_DEFAULT  = 32;
  localparam int CHAR_BUFFER_DEFAULT = 16;

  localparam logic [CHAR_WIDTH-1:0] MINUS_CHAR = 7'h2D;

  // Index 0 is the rightmost entry.
  localparam logic [15:0][CHAR_WIDTH-1:0] DIGIT_CHARS = {
    7'h46, 7'h45, 7'h44, 7'h43, 7'h42, 7'h41, 7'h39, 7'h38,
    7'h37, 7'h36, 7'h35, 7'h34, 7'h33, 7'h32, 7'h31, 7'h30
  };

  typedef struct packed {
    logic load_dec;
    logic load_hex;
    logic dabble;
    logic shift;
  } digit_cmd_t;

  function automatic int dec_digits(input int width);
    return ((width * 1233) >> 12) + 1;
  endfunction

endpackage

// ===== sv/i2a_if.sv =====
interface i2a_num_if;
  logic                               valid;
  logic                               ready;
  logic [i2a_pkg::VALUE_WIDTH-1:0]    value;
  logic                               hex_mode;
  logic                               signed_mode;

  modport source (output valid, value, hex_mode, signed_mode, input ready);
  modport sink   (input valid, value, hex_mode, signed_mode, output ready);
endinterface

interface i2a_char_if;
  logic                               valid;
  logic                               ready;
  logic [i2a_pkg::CHAR_WIDTH-1:0]     character;
  logic                               last;

  modport source (output valid, character, last, input ready);
  modport sink   (input valid, character, last, output ready);
endinterface

// ===== sv/i2a_digits.sv =====
module i2a_digits #(
  parameter int WORD_WIDTH = i2a_pkg::WORD_WIDTH_DEFAULT,
  parameter int NDIG       = i2a_pkg::dec_digits(i2a_pkg::WORD_WIDTH_DEFAULT)
) (
  input  logic                    clk,
  input  i2a_pkg::digit_cmd_t     cmd,
  input  logic [WORD_WIDTH-1:0]   magnitude,
  output logic [3:0]              top_digit
);

  localparam int DW = 4 * NDIG;

  logic [WORD_WIDTH-1:0] magnitude_shift;
  logic [DW-1:0]         bcd_digits;
  logic [DW-1:0]         adjusted;

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_digits[4*i +: 4] >= 4'd5) begin
        adjusted[4*i +: 4] = bcd_digits[4*i +: 4] + 4'd3;
      end else begin
        adjusted[4*i +: 4] = bcd_digits[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.load_dec) begin
      magnitude_shift <= magnitude;
      bcd_digits      <= '0;
    end else if (cmd.load_hex) begin
      magnitude_shift <= magnitude;
      bcd_digits      <= DW'(magnitude);
    end else if (cmd.dabble) begin
      magnitude_shift <= {magnitude_shift[WORD_WIDTH-2:0], 1'b0};
      bcd_digits      <= {adjusted[DW-2:0], magnitude_shift[WORD_WIDTH-1]};
    end else if (cmd.shift) begin
      bcd_digits      <= {bcd_digits[DW-5:0], 4'd0};
    end else begin
      magnitude_shift <= magnitude_shift;
      bcd_digits      <= bcd_digits;
    end
  end

  assign top_digit = bcd_digits[DW-1 -: 4];

endmodule

// ===== sv/integer_to_ascii_converter_core.sv =====
// Base ten loads the magnitude, then runs the shift-and-add-3 conversion over all WORD_WIDTH
//   bits (32 by default), then drops each leading zero digit before the first character.
// Base sixteen loads the nibbles directly and only skips leading zeros.
// Characters then leave at one per cycle while the sink is ready.
// One number at a time: a new number is taken only in idle, after the last character has gone.
// Reset: synchronous, active high; returns to idle with no character pending.
module integer_to_ascii_converter_core #(
  parameter int WORD_WIDTH  = i2a_pkg::WORD_WIDTH_DEFAULT,
  parameter int CHAR_BUFFER = i2a_pkg::CHAR_BUFFER_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  i2a_num_if.sink    num,
  i2a_char_if.source chars
);

  localparam int NDIG = i2a_pkg::dec_digits(WORD_WIDTH);
  localparam int NCW  = $clog2(NDIG + 1);
  localparam int BCW  = $clog2(WORD_WIDTH + 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CONV = 5'b00010,
    ST_SCAN = 5'b00100,
    ST_SIGN = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  state_t               state, state_next;
  logic [NCW-1:0]       digit_count, digit_count_next;
  logic [BCW-1:0]       bit_count, bit_count_next;
  logic                 negative_flag, negative_flag_next;

  i2a_pkg::digit_cmd_t  cmd;
  logic [WORD_WIDTH-1:0] word;
  logic [WORD_WIDTH-1:0] magnitude;
  logic                 negate;
  logic [3:0]           top_digit;
  logic                 accept;
  logic                 drop_digit;

  assign word      = WORD_WIDTH'(num.value);
  assign negate    = !num.hex_mode && num.signed_mode && word[WORD_WIDTH-1];
  assign magnitude = negate ? (~word + WORD_WIDTH'(1)) : word;
  assign accept    = num.valid && num.ready;
  assign drop_digit = (int'(digit_count) > CHAR_BUFFER) ||
                      (top_digit == 4'd0 && digit_count > NCW'(1));

  assign num.ready = (state == ST_IDLE);

  always_comb begin
    state_next         = state;
    digit_count_next   = digit_count;
    bit_count_next     = bit_count;
    negative_flag_next = negative_flag;
    cmd                = '0;
    chars.valid        = 1'b0;
    chars.character    = i2a_pkg::MINUS_CHAR;
    chars.last         = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.load_dec       = !num.hex_mode;
          cmd.load_hex       = num.hex_mode;
          negative_flag_next = negate;
          digit_count_next   = NCW'(NDIG);
          bit_count_next     = BCW'(WORD_WIDTH);
          state_next         = num.hex_mode ? ST_SCAN : ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.dabble     = 1'b1;
        bit_count_next = bit_count - BCW'(1);
        if (bit_count == BCW'(1)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (drop_digit) begin
          cmd.shift        = 1'b1;
          digit_count_next = digit_count - NCW'(1);
        end else if (negative_flag && int'(digit_count) < CHAR_BUFFER) begin
          state_next = ST_SIGN;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_SIGN: begin
        chars.valid = 1'b1;
        if (chars.ready) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        chars.valid     = 1'b1;
        chars.character = i2a_pkg::DIGIT_CHARS[top_digit];
        chars.last      = (digit_count == NCW'(1));
        if (chars.ready) begin
          cmd.shift        = 1'b1;
          digit_count_next = digit_count - NCW'(1);
          if (digit_count == NCW'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      digit_count   <= '0;
      bit_count     <= '0;
      negative_flag <= 1'b0;
    end else begin
      state         <= state_next;
      digit_count   <= digit_count_next;
      bit_count     <= bit_count_next;
      negative_flag <= negative_flag_next;
    end
  end

  i2a_digits #(
    .WORD_WIDTH (WORD_WIDTH),
    .NDIG       (NDIG)
  ) u_digits (
    .clk       (clk),
    .cmd       (cmd),
    .magnitude (magnitude),
    .top_digit (top_digit)
  );

endmodule

// ===== sv/i2a_checker.sv =====
module i2a_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [i2a_pkg::CHAR_WIDTH-1:0]   out_character,
  input logic                             out_last
);

  a_idle_or_busy: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while a character is pending");

  a_no_char_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !out_valid)
    else $error("character offered right after a transaction was taken");

  a_last_frees_input: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_last) |=> (in_ready && !out_valid))
    else $error("block not idle after the final character");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_character) && $stable(out_last)))
    else $error("stalled character changed");

endmodule

bind integer_to_ascii_converter_core i2a_checker u_i2a_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (num.valid),
  .in_ready      (num.ready),
  .out_valid     (chars.valid),
  .out_ready     (chars.ready),
  .out_character (chars.character),
  .out_last      (chars.last)
);
